### hdl/bsc_pkg.sv
// Shared types, opcodes and status codes for the byte stack calculator.
package bsc_pkg;

    localparam int STACK_DEPTH_DEF = 16;

    localparam logic [3:0] MODE_PUSH     = 4'd0;
    localparam logic [3:0] MODE_POP      = 4'd1;
    localparam logic [3:0] MODE_ADD      = 4'd2;
    localparam logic [3:0] MODE_SUB      = 4'd3;
    localparam logic [3:0] MODE_MUL      = 4'd4;
    localparam logic [3:0] MODE_DIV      = 4'd5;
    localparam logic [3:0] MODE_PRINT    = 4'd6;
    localparam logic [3:0] MODE_COMPLETE = 4'd7;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_COMPLETE  = 3'd1;
    localparam logic [2:0] ST_OVERFLOW  = 3'd2;
    localparam logic [2:0] ST_UNDERFLOW = 3'd3;
    localparam logic [2:0] ST_ZERODIV   = 3'd4;
    localparam logic [2:0] ST_INVALID   = 3'd5;

    typedef enum logic [1:0] {
        ALU_ADD = 2'd0,
        ALU_SUB = 2'd1,
        ALU_MUL = 2'd2,
        ALU_DIV = 2'd3
    } t_alu_op;

    typedef struct packed {
        logic [3:0] mode;
        logic [7:0] push_value;
    } t_in_item;

    typedef struct packed {
        logic [2:0] status;
        logic       print_valid;
        logic [7:0] acc_value;
    } t_out_item;

    typedef struct packed {
        logic       start;
        t_alu_op    op;
        logic [7:0] lhs;
        logic [7:0] rhs;
    } t_alu_req;

    typedef struct packed {
        logic       done;
        logic [7:0] result;
    } t_alu_rsp;

endpackage

### hdl/bsc_stack_ram.sv
// Byte stack storage: one write port and one registered read port.
module bsc_stack_ram #(
    parameter int STACK_DEPTH = bsc_pkg::STACK_DEPTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_wr_en,
    input  logic [$clog2(STACK_DEPTH)-1:0] i_wr_addr,
    input  logic [7:0]                     i_wr_data,
    input  logic                           i_rd_en,
    input  logic [$clog2(STACK_DEPTH)-1:0] i_rd_addr,
    output logic [7:0]                     o_rd_data
);
    logic [7:0] r_mem [STACK_DEPTH];
    logic [7:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### hdl/bsc_alu.sv
// Iterative 8-bit unit: add and subtract in one step, multiply and divide in eight.
module bsc_alu (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  bsc_pkg::t_alu_req i_req,
    output bsc_pkg::t_alu_rsp o_rsp
);
    import bsc_pkg::*;

    logic       r_busy;
    logic       r_done;
    logic [2:0] r_cnt;
    t_alu_op    r_op;
    logic [7:0] r_p;   // sum, product or remainder
    logic [7:0] r_q;   // multiplier or dividend/quotient
    logic [7:0] r_b;   // addend, multiplicand or divisor

    logic [8:0] opa;
    logic [8:0] opb;
    logic       sub;
    logic [9:0] sum;
    logic       last;

    // one shared adder serves every operation
    always_comb begin
        opa = {1'b0, r_p};
        opb = {1'b0, r_b};
        sub = 1'b0;
        case (r_op)
            ALU_ADD: begin
            end
            ALU_SUB: begin
                sub = 1'b1;
            end
            ALU_MUL: begin
                opb = r_q[0] ? {1'b0, r_b} : 9'd0;
            end
            ALU_DIV: begin
                opa = {r_p, r_q[7]};
                sub = 1'b1;
            end
            default: begin
            end
        endcase
        sum = {1'b0, opa} + (sub ? ~{1'b0, opb} : {1'b0, opb}) + {9'd0, sub};
    end

    assign last = (r_cnt == 3'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
            end else if (r_busy && last) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_op <= i_req.op;
            case (i_req.op)
                ALU_MUL: begin
                    r_p   <= 8'd0;
                    r_b   <= i_req.lhs;
                    r_q   <= i_req.rhs;
                    r_cnt <= 3'd7;
                end
                ALU_DIV: begin
                    r_p   <= 8'd0;
                    r_q   <= i_req.lhs;
                    r_b   <= i_req.rhs;
                    r_cnt <= 3'd7;
                end
                default: begin
                    r_p   <= i_req.lhs;
                    r_b   <= i_req.rhs;
                    r_cnt <= 3'd0;
                end
            endcase
        end else if (r_busy) begin
            if (!last) begin
                r_cnt <= r_cnt - 3'd1;
            end
            case (r_op)
                ALU_MUL: begin
                    r_p <= sum[7:0];
                    r_b <= {r_b[6:0], 1'b0};
                    r_q <= {1'b0, r_q[7:1]};
                end
                ALU_DIV: begin
                    // restore on a negative trial
                    r_p <= sum[9] ? opa[7:0] : sum[7:0];
                    r_q <= {r_q[6:0], ~sum[9]};
                end
                default: begin
                    r_p <= sum[7:0];
                end
            endcase
        end
    end

    assign o_rsp.done   = r_done;
    assign o_rsp.result = (r_op == ALU_DIV) ? r_q : r_p;

endmodule

### hdl/byte_stack_calculator_unit.sv
// Top level of the byte stack calculator: instruction sequencer, stack and shared ALU.
// One instruction is taken at a time and the input stalls until its result is formed.
// Each instruction passes through decode and a done state; pop adds a stack read, and the
// arithmetic ops read top and second operand through the registered stack read port (one
// operand a cycle) before the shared adder (skipped on a zero divide) steps multiply and
// divide one bit a cycle. A finished result waits in an output register, so the next
// instruction is taken meanwhile; an instruction only finishes once that register is
// empty or being read, so a stalling receiver holds it in its done state.
// Complete or any error returns count and accumulator to zero after the result.
module byte_stack_calculator_unit #(
    parameter int STACK_DEPTH = bsc_pkg::STACK_DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  bsc_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output bsc_pkg::t_out_item o_out_data
);
    import bsc_pkg::*;

    localparam int AW    = $clog2(STACK_DEPTH);
    localparam int CNT_W = $clog2(STACK_DEPTH + 1);

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_DECODE = 7'b0000010,
        S_RD_POP = 7'b0000100,
        S_RD_TOP = 7'b0001000,
        S_RD_SEC = 7'b0010000,
        S_ALU    = 7'b0100000,
        S_DONE   = 7'b1000000
    } t_state;

    t_state           r_state, n_state;
    logic [3:0]       r_mode;
    logic [7:0]       r_imm;
    logic [CNT_W-1:0] r_count, n_count;
    logic [7:0]       r_acc, n_acc;
    logic [2:0]       r_status, n_status;
    logic             r_pv, n_pv;
    logic [7:0]       r_rhs, n_rhs;
    logic             r_out_valid;
    t_out_item        r_out_data;

    logic             in_take;
    logic             slot_free;
    logic             wr_en;
    logic [AW-1:0]    wr_addr;
    logic [7:0]       wr_data;
    logic             rd_en;
    logic [AW-1:0]    rd_addr;
    logic [7:0]       rd_data;
    t_alu_req         alu_req;
    t_alu_rsp         alu_rsp;
    t_alu_op          mode_op;

    assign o_in_stall = (r_state != S_IDLE);
    assign in_take    = i_in_valid && (r_state == S_IDLE);
    assign slot_free  = !r_out_valid || !i_out_stall;

    always_comb begin
        case (r_mode)
            MODE_ADD: mode_op = ALU_ADD;
            MODE_SUB: mode_op = ALU_SUB;
            MODE_MUL: mode_op = ALU_MUL;
            default:  mode_op = ALU_DIV;
        endcase
    end

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_acc    = r_acc;
        n_status = r_status;
        n_pv     = r_pv;
        n_rhs    = r_rhs;
        wr_en    = 1'b0;
        wr_addr  = AW'(r_count);
        wr_data  = r_imm;
        rd_en    = 1'b0;
        rd_addr  = AW'(r_count - CNT_W'(1));
        alu_req  = '{start: 1'b0, op: mode_op, lhs: rd_data, rhs: r_rhs};

        case (r_state)
            S_IDLE: begin
                if (in_take) begin
                    n_status = ST_OK;
                    n_pv     = 1'b0;
                    n_state  = S_DECODE;
                end
            end
            S_DECODE: begin
                n_state = S_DONE;
                case (r_mode)
                    MODE_PUSH: begin
                        if (r_count == CNT_W'(STACK_DEPTH)) begin
                            n_status = ST_OVERFLOW;
                        end else begin
                            wr_en   = 1'b1;
                            n_count = r_count + CNT_W'(1);
                        end
                    end
                    MODE_POP: begin
                        if (r_count == '0) begin
                            n_status = ST_UNDERFLOW;
                        end else begin
                            rd_en   = 1'b1;
                            n_state = S_RD_POP;
                        end
                    end
                    MODE_ADD, MODE_SUB, MODE_MUL, MODE_DIV: begin
                        if (r_count < CNT_W'(2)) begin
                            n_status = ST_UNDERFLOW;
                        end else begin
                            rd_en   = 1'b1;
                            n_state = S_RD_TOP;
                        end
                    end
                    MODE_PRINT: begin
                        n_pv = 1'b1;
                    end
                    MODE_COMPLETE: begin
                        n_status = ST_COMPLETE;
                    end
                    default: begin
                        n_status = ST_INVALID;
                    end
                endcase
            end
            S_RD_POP: begin
                n_acc   = rd_data;
                n_count = r_count - CNT_W'(1);
                n_state = S_DONE;
            end
            S_RD_TOP: begin
                n_rhs   = rd_data;
                rd_en   = 1'b1;
                rd_addr = AW'(r_count - CNT_W'(2));
                n_state = S_RD_SEC;
            end
            S_RD_SEC: begin
                if (r_mode == MODE_DIV && r_rhs == 8'd0) begin
                    n_status = ST_ZERODIV;
                    n_state  = S_DONE;
                end else begin
                    alu_req.start = 1'b1;
                    n_state       = S_ALU;
                end
            end
            S_ALU: begin
                if (alu_rsp.done) begin
                    wr_en   = 1'b1;
                    wr_addr = AW'(r_count - CNT_W'(2));
                    wr_data = alu_rsp.result;
                    n_count = r_count - CNT_W'(1);
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (slot_free) begin
                    n_state = S_IDLE;
                    // drop program state on complete or error
                    if (r_status != ST_OK) begin
                        n_count = '0;
                        n_acc   = 8'd0;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_acc       <= 8'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_acc   <= n_acc;
            if (r_state == S_DONE && slot_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        r_pv     <= n_pv;
        r_rhs    <= n_rhs;
        if (in_take) begin
            r_mode <= i_in_data.mode;
            r_imm  <= i_in_data.push_value;
        end
        if (r_state == S_DONE && slot_free) begin
            r_out_data <= '{status: r_status, print_valid: r_pv, acc_value: r_acc};
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    bsc_stack_ram #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_stack (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    bsc_alu u_alu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (alu_req),
        .o_rsp   (alu_rsp)
    );

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(STACK_DEPTH))
        else $error("stack count beyond depth");

    a_alu_done_in_alu: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        alu_rsp.done |-> r_state == S_ALU)
        else $error("alu result outside alu wait");

    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && slot_free && r_status != ST_OK) |=>
            (r_count == '0 && r_acc == 8'd0))
        else $error("program end did not clear state");

    a_print_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.print_valid) |-> o_out_data.status == ST_OK)
        else $error("print flagged with error status");

endmodule

### test/byte_stack_calculator_unit_tb.sv
// Self-checking testbench for the byte stack calculator: directed table, then random programs.
module byte_stack_calculator_unit_tb;
    import bsc_pkg::*;

    localparam int STACK_DEPTH = STACK_DEPTH_DEF;
    localparam int CYCLE_LIMIT = 500_000;
    localparam int RANDOM_PER_PHASE = 460;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int REPORT_LIMIT = 10;

    localparam logic [3:0] MODE_BAD_LOW  = 4'd8;
    localparam logic [3:0] MODE_BAD_HIGH = 4'd15;

    localparam int GAP_PCT [4]   = '{0, 78, 0, 34};
    localparam int STALL_PCT [4] = '{0, 0, 78, 34};

    typedef struct packed {
        logic [3:0] mode;
        logic [7:0] value;
        logic [4:0] reps;
        logic       fixed;
        t_out_item  want;
    } t_directed_row;

    localparam int DIRECTED_ROWS = 26;
    localparam t_directed_row DIRECTED [DIRECTED_ROWS] = '{
        '{MODE_PRINT,    8'd0,   5'd1,  1'b1, '{ST_OK,        1'b1, 8'd0}},
        '{MODE_POP,      8'd0,   5'd1,  1'b1, '{ST_UNDERFLOW, 1'b0, 8'd0}},
        '{MODE_ADD,      8'd0,   5'd1,  1'b1, '{ST_UNDERFLOW, 1'b0, 8'd0}},
        '{MODE_PUSH,     8'd5,   5'd1,  1'b1, '{ST_OK,        1'b0, 8'd0}},
        '{MODE_SUB,      8'd0,   5'd1,  1'b1, '{ST_UNDERFLOW, 1'b0, 8'd0}},
        '{MODE_PUSH,     8'd255, 5'd1,  1'b1, '{ST_OK,        1'b0, 8'd0}},
        '{MODE_PUSH,     8'd0,   5'd1,  1'b1, '{ST_OK,        1'b0, 8'd0}},
        '{MODE_DIV,      8'd0,   5'd1,  1'b1, '{ST_ZERODIV,   1'b0, 8'd0}},
        '{MODE_PUSH,     8'd200, 5'd1,  1'b0, '0},
        '{MODE_PUSH,     8'd100, 5'd1,  1'b0, '0},
        '{MODE_ADD,      8'd0,   5'd1,  1'b0, '0},
        '{MODE_POP,      8'd0,   5'd1,  1'b0, '0},
        '{MODE_PUSH,     8'd7,   5'd1,  1'b0, '0},
        '{MODE_PUSH,     8'd10,  5'd1,  1'b0, '0},
        '{MODE_SUB,      8'd0,   5'd1,  1'b0, '0},
        '{MODE_PUSH,     8'd3,   5'd1,  1'b0, '0},
        '{MODE_DIV,      8'd0,   5'd1,  1'b0, '0},
        '{MODE_POP,      8'd0,   5'd1,  1'b0, '0},
        '{MODE_PRINT,    8'd0,   5'd1,  1'b0, '0},
        '{MODE_COMPLETE, 8'd0,   5'd1,  1'b0, '0},
        '{MODE_PUSH,     8'd128, 5'd16, 1'b1, '{ST_OK,        1'b0, 8'd0}},
        '{MODE_MUL,      8'd0,   5'd1,  1'b0, '0},
        '{MODE_PUSH,     8'd255, 5'd1,  1'b1, '{ST_OK,        1'b0, 8'd0}},
        '{MODE_PUSH,     8'd1,   5'd1,  1'b1, '{ST_OVERFLOW,  1'b0, 8'd0}},
        '{MODE_BAD_LOW,  8'hAA,  5'd1,  1'b1, '{ST_INVALID,   1'b0, 8'd0}},
        '{MODE_BAD_HIGH, 8'h55,  5'd1,  1'b1, '{ST_INVALID,   1'b0, 8'd0}}
    };

    localparam logic [3:0] NON_PUSH_OPS [13] = '{
        MODE_ADD, MODE_SUB, MODE_MUL, MODE_DIV, MODE_ADD, MODE_SUB, MODE_MUL,
        MODE_DIV, MODE_POP, MODE_POP, MODE_PRINT, MODE_PRINT, MODE_COMPLETE
    };

    logic      clk;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    t_in_item  in_data = '0;
    logic      in_stall;
    logic      out_valid;
    logic      out_stall = 1'b0;
    t_out_item out_data;

    // Shadow copy of the machine state.
    logic [7:0] shadow_stack [STACK_DEPTH];
    int         shadow_depth = 0;
    logic [7:0] shadow_acc = 8'd0;

    t_out_item pending_results [$];
    t_out_item oldest_result;
    int        fault_count = 0;
    int        gap_pct = 0;
    int        stall_pct = 0;
    int        push_bias = 60;
    int        hold_epoch = 0;
    int        seen_epoch = 0;
    int        hold_left = 0;
    int        cycle_count = 0;

    byte_stack_calculator_unit i_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in_data  (in_data),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_data (out_data)
    );

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic t_out_item execute_instruction(t_in_item it);
        t_out_item  res;
        logic [7:0] top;
        logic [7:0] second;
        res = '{ST_OK, 1'b0, 8'd0};
        case (it.mode)
            MODE_PUSH: begin
                if (shadow_depth >= STACK_DEPTH) begin
                    res.status = ST_OVERFLOW;
                end else begin
                    shadow_stack[shadow_depth] = it.push_value;
                    shadow_depth++;
                end
            end
            MODE_POP: begin
                if (shadow_depth == 0) begin
                    res.status = ST_UNDERFLOW;
                end else begin
                    shadow_depth--;
                    shadow_acc = shadow_stack[shadow_depth];
                end
            end
            MODE_ADD, MODE_SUB, MODE_MUL, MODE_DIV: begin
                if (shadow_depth < 2) begin
                    res.status = ST_UNDERFLOW;
                end else begin
                    top    = shadow_stack[shadow_depth - 1];
                    second = shadow_stack[shadow_depth - 2];
                    if (it.mode == MODE_DIV && top == 8'd0) begin
                        res.status = ST_ZERODIV;
                    end else begin
                        shadow_depth -= 2;
                        case (it.mode)
                            MODE_ADD: shadow_stack[shadow_depth] = second + top;
                            MODE_SUB: shadow_stack[shadow_depth] = second - top;
                            MODE_MUL: shadow_stack[shadow_depth] = second * top;
                            default:  shadow_stack[shadow_depth] = second / top;
                        endcase
                        shadow_depth++;
                    end
                end
            end
            MODE_PRINT:    res.print_valid = 1'b1;
            MODE_COMPLETE: res.status = ST_COMPLETE;
            default:       res.status = ST_INVALID;
        endcase
        res.acc_value = shadow_acc;
        // Program ends: clear for the next one.
        if (res.status != ST_OK) begin
            shadow_depth = 0;
            shadow_acc   = 8'd0;
        end
        return res;
    endfunction

    // Mostly well-formed programs, with a little noise mixed in.
    function automatic t_in_item pick_instruction();
        t_in_item it;
        int       roll;
        roll = $urandom_range(9);
        if (roll == 0) it.push_value = 8'd0;
        else if (roll == 1) it.push_value = 8'd255;
        else if (roll == 2) it.push_value = 8'd1;
        else it.push_value = 8'($urandom_range(255));
        roll = $urandom_range(99);
        if (roll < 7) begin
            it.mode = 4'($urandom_range(15));
        end else if (shadow_depth < 2 && roll < 95) begin
            it.mode = MODE_PUSH;
        end else if ($urandom_range(99) < push_bias) begin
            it.mode = MODE_PUSH;
        end else begin
            it.mode = NON_PUSH_OPS[$urandom_range(12)];
        end
        return it;
    endfunction

    task automatic issue(input t_in_item it, input logic fixed, input t_out_item want);
        bit        taken;
        t_out_item predicted;
        in_valid <= 1'b1;
        in_data  <= it;
        do begin
            @(negedge clk);
            taken = !in_stall;
            @(posedge clk);
        end while (!taken);
        predicted = execute_instruction(it);
        pending_results.push_back(fixed ? want : predicted);
        if (predicted.status != ST_OK)
            push_bias = $urandom_range(30, 85);
        while ($urandom_range(99) < gap_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
    endtask

    // Receiver stall, with a single long hold-off at the start of the random programs to back the block up.
    always @(posedge clk) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else if (hold_epoch != seen_epoch) begin
            seen_epoch <= hold_epoch;
            hold_left  <= HOLD_OFF_CYCLES;
            out_stall  <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end else begin
            out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    always @(negedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            if (pending_results.size() == 0) begin
                fault_count++;
                if (fault_count <= REPORT_LIMIT)
                    $display("unexpected transaction: status=%0d print=%0b acc=%0d",
                             out_data.status, out_data.print_valid, out_data.acc_value);
            end else begin
                oldest_result = pending_results.pop_front();
                if (out_data.status !== oldest_result.status
                        || out_data.print_valid !== oldest_result.print_valid
                        || out_data.acc_value !== oldest_result.acc_value) begin
                    fault_count++;
                    if (fault_count <= REPORT_LIMIT)
                        $display("mismatch: expected status=%0d print=%0b acc=%0d, got %0d %0b %0d",
                                 oldest_result.status, oldest_result.print_valid,
                                 oldest_result.acc_value, out_data.status,
                                 out_data.print_valid, out_data.acc_value);
                end
            end
        end
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        gap_pct = 34;
        stall_pct <= 34;
        for (int r = 0; r < DIRECTED_ROWS; r++) begin
            for (int k = 0; k < DIRECTED[r].reps; k++)
                issue('{DIRECTED[r].mode, DIRECTED[r].value}, DIRECTED[r].fixed,
                      DIRECTED[r].want);
        end

        for (int ph = 0; ph < 4; ph++) begin
            gap_pct = GAP_PCT[ph];
            stall_pct <= STALL_PCT[ph];
            if (ph == 0)
                hold_epoch <= hold_epoch + 1;
            for (int n = 0; n < RANDOM_PER_PHASE; n++)
                issue(pick_instruction(), 1'b0, '0);
        end

        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (fault_count == 0 && pending_results.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

### filelist.f
hdl/bsc_pkg.sv
hdl/bsc_stack_ram.sv
hdl/bsc_alu.sv
hdl/byte_stack_calculator_unit.sv
test/byte_stack_calculator_unit_tb.sv
